/* src/lqs_pkg.sv */
package lqs_pkg;

   localparam int TIME_W  = 24;
   localparam int ID_W    = 16;
   localparam int PRI_W   = 8;
   localparam int RAND_W  = 31;
   localparam int QUANT_W = 16;
   localparam int PCNT_W  = 5;
   localparam int DRAWN_W = 11;
   localparam int SLOT_W  = 4;
   localparam int KIND_W  = 2;
   localparam int CSR_A_W = 1;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RAN  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_IDLE = 2'd2;

   localparam logic [CSR_A_W-1:0] CSR_QUANTUM    = 1'b0;
   localparam logic [CSR_A_W-1:0] CSR_PROC_COUNT = 1'b1;

   localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd10;
   localparam logic [PCNT_W-1:0]  PCOUNT_RESET  = 5'd16;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [SLOT_W-1:0]  winner_slot;
      logic [ID_W-1:0]    winner_id;
      logic [DRAWN_W-1:0] drawn_ticket;
      logic [QUANT_W-1:0] run_time;
      logic [TIME_W-1:0]  time_now;
      logic               first_run;
      logic [TIME_W-1:0]  latency;
      logic               finished;
      logic [TIME_W-1:0]  turnaround;
      logic [TIME_W-1:0]  waiting_time;
      logic               all_done;
   } rsp_type;

endpackage

/* src/lqs_channels.sv */
interface lqs_req_if import lqs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              mode;
   logic [SLOT_W-1:0] slot;
   logic [ID_W-1:0]   proc_id;
   logic [TIME_W-1:0] arrival_time;
   logic [TIME_W-1:0] burst_time;
   logic [PRI_W-1:0]  priority_req;
   logic [RAND_W-1:0] random_word;

   modport source (output valid, mode, slot, proc_id, arrival_time, burst_time,
                   priority_req, random_word, input ready);
   modport sink (input valid, mode, slot, proc_id, arrival_time, burst_time,
                 priority_req, random_word, output ready);
endinterface

interface lqs_rsp_if import lqs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [SLOT_W-1:0]  winner_slot;
   logic [ID_W-1:0]    winner_id;
   logic [DRAWN_W-1:0] drawn_ticket;
   logic [QUANT_W-1:0] run_time;
   logic [TIME_W-1:0]  time_now;
   logic               first_run;
   logic [TIME_W-1:0]  latency;
   logic               finished;
   logic [TIME_W-1:0]  turnaround;
   logic [TIME_W-1:0]  waiting_time;
   logic               all_done;

   modport source (output valid, kind, winner_slot, winner_id, drawn_ticket, run_time,
                   time_now, first_run, latency, finished, turnaround, waiting_time,
                   all_done, input ready);
   modport sink (input valid, kind, winner_slot, winner_id, drawn_ticket, run_time,
                 time_now, first_run, latency, finished, turnaround, waiting_time,
                 all_done, output ready);
endinterface

/* src/lottery_quantum_scheduler.sv */
// Lottery scheduler with a time quantum. A load item (mode 0) writes one process
// slot in S_LDW and is then answered from S_RSP. A draw item (mode 1) walks the
// active slots once to admit arrivals, reduces the random word modulo the ticket
// pool with a one-bit-per-cycle restoring divider, walks the memory again for the
// ticket prefix sum and then updates the winner in S_RUN, S_ADV and S_OUT before
// S_RSP; its length is set by the single read port of the slot memory and the
// serial divider. A draw with all slots finished or no ticket to draw is answered
// as idle. One item is in work at a time; the result sits in an output register,
// so the next item is taken while it waits. Slot records live in a synchronous
// memory; arrived, finished and started flags are flip-flops cleared by reset.
module lottery_quantum_scheduler
   import lqs_pkg::*;
#(
   parameter int MAX_SLOTS   = 16,
   parameter int TICKET_BASE = 100
) (
   input  logic               clock,
   input  logic               reset,
   lqs_req_if.sink            req_ch,
   lqs_rsp_if.source          rsp_ch,
   input  logic               csr_we,
   input  logic [CSR_A_W-1:0] csr_index,
   input  logic [QUANT_W-1:0] csr_data
);

   localparam int SW = $clog2(MAX_SLOTS);
   localparam int NW = $clog2(MAX_SLOTS + 1);
   localparam int TW = $clog2(TICKET_BASE + 1);
   localparam int PW = $clog2(MAX_SLOTS * TICKET_BASE + 1);
   localparam int CW = $clog2(RAND_W);

   typedef struct packed {
      logic [ID_W-1:0]   ident;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [TIME_W-1:0] remaining;
      logic [TW-1:0]     tickets;
   } rec_type;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_LDW  = 9'b000000010,
      S_ARR  = 9'b000000100,
      S_DIV  = 9'b000001000,
      S_PFX  = 9'b000010000,
      S_RUN  = 9'b000100000,
      S_ADV  = 9'b001000000,
      S_OUT  = 9'b010000000,
      S_RSP  = 9'b100000000
   } state_type;

   rec_type mem [MAX_SLOTS];
   rec_type rd_ff;
   logic [SW-1:0] rd_addr;
   logic          wr_en;
   logic [SW-1:0] wr_addr;
   rec_type       wr_data;

   state_type state_ff, state_in;
   logic [MAX_SLOTS-1:0] arrived_ff, arrived_in;
   logic [MAX_SLOTS-1:0] finished_ff, finished_in;
   logic [MAX_SLOTS-1:0] started_ff, started_in;
   logic [TIME_W-1:0] clock_ff, clock_in;
   logic [PW-1:0] pool_ff, pool_in;
   logic [NW-1:0] fcount_ff, fcount_in;
   logic [QUANT_W-1:0] quantum_ff;
   logic [PCNT_W-1:0] pcount_ff;

   logic [NW-1:0] cnt_ff, cnt_in;
   logic          vld_ff, vld_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [CW-1:0] dcnt_ff, dcnt_in;
   logic [PW:0]   rem_ff, rem_in;
   logic [PW-1:0] sum_ff, sum_in;
   logic [SW-1:0] widx_ff, widx_in;
   rec_type       win_ff, win_in;

   logic [SW-1:0]     lslot_ff, lslot_in;
   rec_type           lrec_ff, lrec_in;
   logic [RAND_W-1:0] rw_ff, rw_in;

   rsp_type res_ff, res_in;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   logic [NW-1:0]     n_eff;
   logic              out_free;
   logic [PW:0]       rem_sh;
   logic [PW-1:0]     sum_nx;
   logic [TIME_W:0]   clk_sum;
   logic [TIME_W-1:0] clk_sat;
   logic [TIME_W-1:0] new_rem;
   logic [TIME_W-1:0] ta;
   logic [PRI_W-1:0]  tbase;

   assign n_eff = (int'(pcount_ff) > MAX_SLOTS) ? NW'(MAX_SLOTS) : NW'(pcount_ff);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign tbase = PRI_W'(TICKET_BASE);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      arrived_in   = arrived_ff;
      finished_in  = finished_ff;
      started_in   = started_ff;
      clock_in     = clock_ff;
      pool_in      = pool_ff;
      fcount_in    = fcount_ff;
      cnt_in       = cnt_ff;
      vld_in       = 1'b0;
      idx_in       = idx_ff;
      dcnt_in      = dcnt_ff;
      rem_in       = rem_ff;
      sum_in       = sum_ff;
      widx_in      = widx_ff;
      win_in       = win_ff;
      lslot_in     = lslot_ff;
      lrec_in      = lrec_ff;
      rw_in        = rw_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rd_addr      = cnt_ff[SW-1:0];
      wr_en        = 1'b0;
      wr_addr      = widx_ff;
      wr_data      = win_ff;
      rem_sh       = {rem_ff[PW-1:0], rw_ff[RAND_W-1]};
      sum_nx       = sum_ff + PW'(rd_ff.tickets);
      clk_sum      = {1'b0, clock_ff} + (TIME_W+1)'(res_ff.run_time);
      clk_sat      = clk_sum[TIME_W] ? TIME_MAX : clk_sum[TIME_W-1:0];
      new_rem      = win_ff.remaining - TIME_W'(res_ff.run_time);
      ta           = clock_ff - win_ff.arrival;

      case (state_ff)
         S_IDLE: begin
            rd_addr = SW'(req_ch.slot);
            if (req_ch.valid) begin
               res_in = '0;
               lslot_in = SW'(req_ch.slot);
               rw_in = req_ch.random_word;
               lrec_in.ident = req_ch.proc_id;
               lrec_in.arrival = req_ch.arrival_time;
               lrec_in.burst = req_ch.burst_time;
               lrec_in.remaining = req_ch.burst_time;
               lrec_in.tickets = (req_ch.priority_req < tbase) ?
                                 TW'(tbase - req_ch.priority_req) : '0;
               if (!req_ch.mode) begin
                  res_in.kind = KIND_LOAD;
                  // slots beyond the table are acknowledged and dropped
                  state_in = (int'(req_ch.slot) < MAX_SLOTS) ? S_LDW : S_RSP;
               end else if (fcount_ff >= n_eff) begin
                  res_in.kind = KIND_IDLE;
                  state_in = S_RSP;
               end else begin
                  cnt_in = '0;
                  state_in = S_ARR;
               end
            end
         end
         S_LDW: begin
            if (arrived_ff[lslot_ff] && !finished_ff[lslot_ff]) begin
               pool_in = (pool_ff >= PW'(rd_ff.tickets)) ? pool_ff - PW'(rd_ff.tickets) : '0;
            end
            if (finished_ff[lslot_ff] && fcount_ff != '0) begin
               fcount_in = fcount_ff - 1'b1;
            end
            arrived_in[lslot_ff] = 1'b0;
            finished_in[lslot_ff] = 1'b0;
            started_in[lslot_ff] = 1'b0;
            wr_en = 1'b1;
            wr_addr = lslot_ff;
            wr_data = lrec_ff;
            state_in = S_RSP;
         end
         S_ARR: begin
            if (vld_ff && !arrived_ff[idx_ff] && rd_ff.arrival <= clock_ff) begin
               arrived_in[idx_ff] = 1'b1;
               pool_in = pool_ff + PW'(rd_ff.tickets);
            end
            if (cnt_ff < n_eff) begin
               vld_in = 1'b1;
               idx_in = cnt_ff[SW-1:0];
               cnt_in = cnt_ff + 1'b1;
            end else if (!vld_ff) begin
               rem_in = '0;
               dcnt_in = '0;
               if (pool_ff == '0) begin
                  clock_in = (clock_ff == TIME_MAX) ? clock_ff : clock_ff + 1'b1;
                  res_in.kind = KIND_IDLE;
                  state_in = S_RSP;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            rem_in = (rem_sh >= {1'b0, pool_ff}) ? rem_sh - {1'b0, pool_ff} : rem_sh;
            rw_in = {rw_ff[RAND_W-2:0], 1'b0};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == CW'(RAND_W - 1)) begin
               cnt_in = '0;
               sum_in = '0;
               state_in = S_PFX;
            end
         end
         S_PFX: begin
            if (vld_ff && arrived_ff[idx_ff] && !finished_ff[idx_ff]) begin
               sum_in = sum_nx;
               if (sum_nx > rem_ff[PW-1:0]) begin
                  widx_in = idx_ff;
                  win_in = rd_ff;
                  state_in = S_RUN;
               end
            end
            if (state_in == S_PFX) begin
               if (cnt_ff < n_eff) begin
                  vld_in = 1'b1;
                  idx_in = cnt_ff[SW-1:0];
                  cnt_in = cnt_ff + 1'b1;
               end else if (!vld_ff) begin
                  clock_in = (clock_ff == TIME_MAX) ? clock_ff : clock_ff + 1'b1;
                  res_in.kind = KIND_IDLE;
                  state_in = S_RSP;
               end
            end
         end
         S_RUN: begin
            res_in.kind = KIND_RAN;
            res_in.winner_slot = SLOT_W'(widx_ff);
            res_in.winner_id = win_ff.ident;
            res_in.drawn_ticket = DRAWN_W'(rem_ff);
            res_in.run_time = (win_ff.remaining < TIME_W'(quantum_ff)) ?
                              QUANT_W'(win_ff.remaining) : quantum_ff;
            if (!started_ff[widx_ff]) begin
               started_in[widx_ff] = 1'b1;
               res_in.first_run = 1'b1;
               res_in.latency = clock_ff - win_ff.arrival;
            end
            state_in = S_ADV;
         end
         S_ADV: begin
            clock_in = clk_sat;
            win_in.remaining = new_rem;
            wr_en = 1'b1;
            wr_addr = widx_ff;
            wr_data = win_ff;
            wr_data.remaining = new_rem;
            if (new_rem == '0) begin
               finished_in[widx_ff] = 1'b1;
               pool_in = (pool_ff >= PW'(win_ff.tickets)) ? pool_ff - PW'(win_ff.tickets) : '0;
               fcount_in = fcount_ff + 1'b1;
               res_in.finished = 1'b1;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (res_ff.finished) begin
               res_in.turnaround = ta;
               res_in.waiting_time = (ta >= win_ff.burst) ? ta - win_ff.burst : '0;
            end
            state_in = S_RSP;
         end
         S_RSP: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_in = res_ff;
               rsp_in.time_now = clock_ff;
               rsp_in.all_done = (fcount_ff >= n_eff);
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         arrived_ff   <= '0;
         finished_ff  <= '0;
         started_ff   <= '0;
         clock_ff     <= '0;
         pool_ff      <= '0;
         fcount_ff    <= '0;
         quantum_ff   <= QUANTUM_RESET;
         pcount_ff    <= PCOUNT_RESET;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         arrived_ff   <= arrived_in;
         finished_ff  <= finished_in;
         started_ff   <= started_in;
         clock_ff     <= clock_in;
         pool_ff      <= pool_in;
         fcount_ff    <= fcount_in;
         rsp_valid_ff <= rsp_valid_in;
         vld_ff       <= vld_in;
         if (csr_we) begin
            case (csr_index)
               CSR_QUANTUM:    quantum_ff <= csr_data;
               CSR_PROC_COUNT: pcount_ff <= csr_data[PCNT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      dcnt_ff  <= dcnt_in;
      rem_ff   <= rem_in;
      sum_ff   <= sum_in;
      widx_ff  <= widx_in;
      win_ff   <= win_in;
      lslot_ff <= lslot_in;
      lrec_ff  <= lrec_in;
      rw_ff    <= rw_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.kind         = rsp_ff.kind;
   assign rsp_ch.winner_slot  = rsp_ff.winner_slot;
   assign rsp_ch.winner_id    = rsp_ff.winner_id;
   assign rsp_ch.drawn_ticket = rsp_ff.drawn_ticket;
   assign rsp_ch.run_time     = rsp_ff.run_time;
   assign rsp_ch.time_now     = rsp_ff.time_now;
   assign rsp_ch.first_run    = rsp_ff.first_run;
   assign rsp_ch.latency      = rsp_ff.latency;
   assign rsp_ch.finished     = rsp_ff.finished;
   assign rsp_ch.turnaround   = rsp_ff.turnaround;
   assign rsp_ch.waiting_time = rsp_ff.waiting_time;
   assign rsp_ch.all_done     = rsp_ff.all_done;

endmodule
